>>> rtl/ict_pkg.sv
// Shared types and constants of the in-order commit tracker.
package ict_pkg;

	// Reorder window depth. It must be a power of two so that the slot of a
	// sequence number is its low bits.
	localparam int WINDOW = 64;
	localparam int SLOT_W = $clog2(WINDOW);

	localparam int SEQ_W   = 31;
	localparam int CIDX_W  = 32;
	localparam int NODE_W  = 8;
	localparam int TOTAL_W = 31;
	localparam int CFG_W   = 31;
	localparam int CFG_IDX_W = 1;

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [SEQ_W-1:0]     seq_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_OWN_NODE_ID   = 1'b0;
	localparam cfg_idx_t REG_TOTAL_REQUESTS = 1'b1;

	// Write request into the mark memory.
	typedef struct packed {
		logic  en;
		slot_t addr;
		seq_t  tag;
	} mem_wr_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MARK = 4'b0010,
		S_WALK = 4'b0100,
		S_RES  = 4'b1000
	} state_t;

endpackage

>>> rtl/in_order_commit_tracker.sv
// Top level of the in-order commit tracker: sequencer, registers and result stage.
//
// Usage: each input beat on the seq_number channel (in_valid / in_stall)
// carries one arriving sequence number. Every accepted beat produces exactly
// one result beat on the output channel (out_valid / out_stall) holding the
// new commit index, the node id, a dropped flag for numbers beyond the
// window and the finished flag.
// Items are handled one at a time. An item is first marked, then the walk
// advances the commit index over each consecutive entry that is present,
// checking the entries one by one through the single read port of the mark
// memory until a walk step finds the gap, and then the result is loaded into
// the output register once that register is free. A finished item skips the
// walk. The next item is taken only after its predecessor has been loaded
// into the output register.
// A waiting result blocks the input: the sequencer keeps in_stall high until
// the result is loaded, which waits until the receiver takes any held beat.
// Reset clears the valid bits of the window at once, sets the commit index
// to minus one, clears the finished flag, the node id to zero and the total
// to one. The user must write the registers through cfg_we / cfg_index /
// cfg_data only while the block is idle; the block does not enforce this.
module in_order_commit_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ict_pkg::SEQ_W-1:0]     seq_number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [ict_pkg::CIDX_W-1:0] commit_index,
	output logic [ict_pkg::NODE_W-1:0]    sender_node,
	output logic                          dropped,
	output logic                          finished,
	input  logic                          cfg_we,
	input  ict_pkg::cfg_idx_t             cfg_index,
	input  logic [ict_pkg::CFG_W-1:0]     cfg_data
);

	ict_pkg::state_t                 state_q;
	logic [ict_pkg::NODE_W-1:0]      own_node_id_q;
	logic [ict_pkg::TOTAL_W-1:0]     total_q;
	// Next sequence number expected in order, that is the commit index plus one.
	logic [ict_pkg::CIDX_W-1:0]      cp1_q;
	logic                            done_q;
	ict_pkg::seq_t                   seq_q;
	logic                            drop_q;

	logic                            out_valid_q;
	logic [ict_pkg::CIDX_W-1:0]      commit_q;
	logic [ict_pkg::NODE_W-1:0]      sender_q;
	logic                            dropped_q;
	logic                            finished_q;

	ict_pkg::mem_wr_t                mem_wr;
	ict_pkg::slot_t                  rd_addr;
	ict_pkg::seq_t                   rd_tag;
	logic                            rd_valid;

	logic                            in_accept;
	logic                            done_now;
	logic                            above_commit;
	logic                            beyond_window;
	logic                            walk_hit;
	logic                            out_free;
	logic [ict_pkg::CIDX_W-1:0]      cp1_next;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ict_pkg::S_IDLE);
	assign cp1_next  = cp1_q + 32'd1;

	// The tracker counts as finished once the commit index has reached the
	// total minus one; a later total is honored only until it has finished.
	assign done_now = done_q || (cp1_q >= {1'b0, total_q});

	assign above_commit  = ({1'b0, seq_q} >= cp1_q);
	assign beyond_window = ({2'b00, seq_q} >
		({1'b0, cp1_q} + 33'(ict_pkg::WINDOW - 1)));

	// The mark is written while the item is classified; the memory forwards
	// it when the same cycle reads the slot of the expected number.
	always_comb begin
		mem_wr.en   = (state_q == ict_pkg::S_MARK) && !done_now && above_commit &&
			!beyond_window;
		mem_wr.addr = seq_q[ict_pkg::SLOT_W-1:0];
		mem_wr.tag  = seq_q;
	end

	// During the walk the read for the following number is issued every cycle,
	// so one entry is checked per cycle.
	assign rd_addr = (state_q == ict_pkg::S_MARK) ? cp1_q[ict_pkg::SLOT_W-1:0] :
		cp1_next[ict_pkg::SLOT_W-1:0];

	// A hit needs the expected number to lie within the 31-bit sequence range.
	assign walk_hit = rd_valid && !cp1_q[ict_pkg::CIDX_W-1] &&
		(rd_tag == cp1_q[ict_pkg::SEQ_W-1:0]);

	assign out_free = !out_valid_q || !out_stall;

	ict_mark_mem u_mark_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (mem_wr),
		.rd_addr  (rd_addr),
		.rd_tag   (rd_tag),
		.rd_valid (rd_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_id_q <= '0;
			total_q       <= 31'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ict_pkg::REG_OWN_NODE_ID:    own_node_id_q <= cfg_data[ict_pkg::NODE_W-1:0];
				ict_pkg::REG_TOTAL_REQUESTS: total_q       <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			seq_q <= seq_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ict_pkg::S_IDLE;
			cp1_q   <= '0;
			done_q  <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ict_pkg::S_IDLE: begin
					if (in_accept) begin
						state_q <= ict_pkg::S_MARK;
					end
				end
				ict_pkg::S_MARK: begin
					if (done_now) begin
						done_q  <= 1'b1;
						drop_q  <= 1'b0;
						state_q <= ict_pkg::S_RES;
					end else begin
						drop_q  <= above_commit && beyond_window;
						state_q <= ict_pkg::S_WALK;
					end
				end
				ict_pkg::S_WALK: begin
					if (walk_hit) begin
						cp1_q <= cp1_next;
					end else begin
						state_q <= ict_pkg::S_RES;
					end
				end
				ict_pkg::S_RES: begin
					if (out_free) begin
						done_q  <= done_now;
						state_q <= ict_pkg::S_IDLE;
					end
				end
				default: state_q <= ict_pkg::S_IDLE;
			endcase
		end
	end

	// Output register: it holds a beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ict_pkg::S_RES) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ict_pkg::S_RES) && out_free) begin
			commit_q   <= cp1_q - 32'd1;
			sender_q   <= own_node_id_q;
			dropped_q  <= drop_q;
			finished_q <= done_now;
		end
	end

	assign out_valid    = out_valid_q;
	assign commit_index = commit_q;
	assign sender_node  = sender_q;
	assign dropped      = dropped_q;
	assign finished     = finished_q;

	// An accepted beat always starts classification in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ict_pkg::S_MARK))
		else $error("accepted beat did not start classification");

	// The commit index never moves backward.
	assert property (@(posedge clk) disable iff (!arst_n)
		##1 (cp1_q >= $past(cp1_q)))
		else $error("commit index moved backward");

	// Once finished, the commit index is frozen.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> (cp1_q == $past(cp1_q)))
		else $error("commit index changed after finish");

	// A walk that finds no present mark ends in the result state.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ict_pkg::S_WALK) && !walk_hit) |=> (state_q == ict_pkg::S_RES))
		else $error("walk did not end on a missing mark");

endmodule

>>> rtl/ict_mark_mem.sv
// Mark memory: one stored sequence number per window slot, with valid bits.
module ict_mark_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  ict_pkg::mem_wr_t  wr,
	input  ict_pkg::slot_t    rd_addr,
	output ict_pkg::seq_t     rd_tag,
	output logic              rd_valid
);

	ict_pkg::seq_t              mem_q [ict_pkg::WINDOW];
	logic [ict_pkg::WINDOW-1:0] valid_q;
	ict_pkg::seq_t              rd_tag_q;
	logic                       rd_valid_q;
	logic                       same_addr;

	assign same_addr = wr.en && (wr.addr == rd_addr);

	// A slot holds the sequence number that last marked it. The mark counts as
	// present only when the stored number equals the one being looked for, so
	// committed entries never need to be cleared.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.tag;
		end
		if (same_addr) begin
			rd_tag_q <= wr.tag;
		end else begin
			rd_tag_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rd_valid_q <= same_addr | valid_q[rd_addr];
		end
	end

	assign rd_tag   = rd_tag_q;
	assign rd_valid = rd_valid_q;

endmodule
